FILE: rtl/core/rsa_pkg.sv
`default_nettype none
package rsa_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int GRP_W     = 11;
	localparam int SCORE_W   = 32;
	localparam int RSUM_W    = 21;
	localparam int DRANK_W   = CNT_W + 1;
	localparam int PROD_W    = 2 * GRP_W + 1;
	localparam int UD_W      = 22;
	localparam int AUC_W     = 17;
	localparam int FRAC_W    = 16;
	localparam int DIVD_W    = PROD_W + FRAC_W + 1;
	localparam int DCNT_W    = $clog2(DIVD_W + 1);
	localparam int ENTRY_W   = SCORE_W + 2;

	typedef enum logic {
		REG_N1 = 1'b0,
		REG_N2 = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rd_i;
		logic latch;
		logic add_miss;
		logic scan_init;
		logic scan_rd;
		logic add_valid;
		logic next_i;
		logic mul;
		logic subt;
		logic div_init;
		logic div_step;
		logic emit;
	} rsa_cmd_t;

	typedef struct packed {
		logic i_end;
		logic j_end;
		logic div_done;
		logic cur_label;
		logic cur_miss;
		logic out_busy;
	} rsa_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/rank_sum_auroc.sv
`default_nettype none
// Mann-Whitney rank-sum AUROC. Words (score, label, missing flag) are stored
// until the word with tlast; then every valid label-0 item is ranked by a full
// compare scan over the store (one stored word per cycle through the single
// read port), tied scores taking their averaged rank kept doubled, missing
// scores ranking after all valid ones in arrival order. Twice U and
// AUC = 1 - U/(n1*n2) in Q1.16 (rounded, clamped) follow, the quotient from
// a 40-step restoring divider. Loading accepts words back to back; tready is
// low from the last word until the result is emitted. A zero group count sets
// the error flag and auc reads 0. Items beyond 1024 are dropped. The result is
// held in an output register until taken; loading of the next set may start
// meanwhile.
module rank_sum_auroc import rsa_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration: index 0 = n1 (label-0 count), 1 = n2
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [10:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,   // score
	input  wire logic [1:0]   s_axis_tuser,   // label, is_missing
	input  wire logic         s_axis_tlast,   // last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // auc[16:0], u_doubled[38:17], zero
	output logic              m_axis_tuser    // error
);

	rsa_cmd_t         cmd;
	rsa_stat_t        stat;
	logic [AUC_W-1:0] auc;
	logic [UD_W-1:0]  ud;

	rsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_score  (s_axis_tdata),
		.in_label  (s_axis_tuser[0]),
		.in_miss   (s_axis_tuser[1]),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_auc   (auc),
		.out_ud    (ud),
		.out_err   (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, ud, auc};

endmodule
`default_nettype wire

FILE: rtl/core/rsa_ctrl.sv
`default_nettype none
module rsa_ctrl import rsa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	input  rsa_stat_t stat,
	output rsa_cmd_t  cmd
);

	typedef enum logic [3:0] {
		IDLE, START, ITEM, DECIDE, SCAN, DRAIN, ADDV, NEXT,
		MUL, SUBT, DINIT, DIV, EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:   cmd.load = in_valid;
			START:  cmd.start = 1'b1;
			ITEM:   cmd.rd_i = !stat.i_end;
			DECIDE: begin
				cmd.latch     = 1'b1;
				cmd.add_miss  = !stat.cur_label && stat.cur_miss;
				cmd.scan_init = 1'b1;
			end
			SCAN:   cmd.scan_rd = !stat.j_end;
			DRAIN:  ;
			ADDV:   cmd.add_valid = 1'b1;
			NEXT:   cmd.next_i = 1'b1;
			MUL:    cmd.mul = 1'b1;
			SUBT:   cmd.subt = 1'b1;
			DINIT:  cmd.div_init = 1'b1;
			DIV:    cmd.div_step = !stat.div_done;
			EMIT:   cmd.emit = !stat.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE:   if (in_valid && in_last) state_q <= START;
				START:  state_q <= ITEM;
				ITEM:   state_q <= stat.i_end ? MUL : DECIDE;
				DECIDE: begin
					if (stat.cur_label || stat.cur_miss) state_q <= NEXT;
					else state_q <= SCAN;
				end
				SCAN:   if (stat.j_end) state_q <= DRAIN;
				DRAIN:  state_q <= ADDV;
				ADDV:   state_q <= NEXT;
				NEXT:   state_q <= ITEM;
				MUL:    state_q <= SUBT;
				SUBT:   state_q <= DINIT;
				DINIT:  state_q <= DIV;
				DIV:    if (stat.div_done) state_q <= EMIT;
				EMIT:   if (!stat.out_busy) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rsa_dp.sv
`default_nettype none
module rsa_dp import rsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [GRP_W-1:0]   cfg_data,
	input  wire logic [SCORE_W-1:0] in_score,
	input  wire logic               in_label,
	input  wire logic               in_miss,
	input  rsa_cmd_t                cmd,
	output rsa_stat_t               stat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [AUC_W-1:0]        out_auc,
	output logic [UD_W-1:0]         out_ud,
	output logic                    out_err
);

	logic [ENTRY_W-1:0] mem [MAX_ITEMS];
	logic [ENTRY_W-1:0] rd_q;
	logic [ADDR_W-1:0]  rd_addr;

	logic [GRP_W-1:0]   n1_q, n2_q;
	logic [CNT_W-1:0]   cnt_q, vcnt_q, i_q, j_q, mrun_q, below_q, equal_q;
	logic [SCORE_W-1:0] cur_score_q;
	logic               cur_miss_q;
	logic               cmp_s1;
	logic [RSUM_W-1:0]  rsum_q;
	logic [PROD_W-1:0]  sub_q, den_q;
	logic               err_q;
	logic [UD_W-1:0]    ud_q;
	logic [DIVD_W-1:0]  divd_q;
	logic [PROD_W-1:0]  rem_q;
	logic [AUC_W-1:0]   quo_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               out_valid_q;

	logic [SCORE_W-1:0] rd_score;
	logic               rd_miss;
	logic [PROD_W-1:0]  diff;
	logic [PROD_W-1:0]  num;
	logic [PROD_W:0]    trial;
	logic               ge;
	logic [DRANK_W-1:0] vrank, mrank;

	assign rd_addr  = cmd.rd_i ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];
	assign rd_score = rd_q[SCORE_W-1:0];
	assign rd_miss  = rd_q[SCORE_W+1];

	assign stat.i_end     = (i_q == cnt_q);
	assign stat.j_end     = (j_q == cnt_q);
	assign stat.div_done  = (dcnt_q == DCNT_W'(DIVD_W));
	assign stat.cur_label = rd_q[SCORE_W];
	assign stat.cur_miss  = rd_miss;
	assign stat.out_busy  = out_valid_q;

	assign vrank = {below_q, 1'b0} + DRANK_W'(equal_q) + DRANK_W'(1);
	assign mrank = {vcnt_q + mrun_q + CNT_W'(1), 1'b0};
	assign diff  = {{(PROD_W-RSUM_W){1'b0}}, rsum_q} - sub_q;
	assign num   = (den_q > PROD_W'(ud_q)) ? den_q - PROD_W'(ud_q) : '0;
	assign trial = {rem_q, divd_q[DIVD_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	// store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CNT_W'(MAX_ITEMS)))
			mem[cnt_q[ADDR_W-1:0]] <= {in_miss, in_label, in_score};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cur_score_q <= rd_score;
			cur_miss_q  <= rd_miss;
		end
		if (cmd.mul) begin
			sub_q <= PROD_W'(n1_q) * (PROD_W'(n1_q) + PROD_W'(1));
			den_q <= {(PROD_W-1)'(n1_q) * (PROD_W-1)'(n2_q), 1'b0};
			err_q <= (n1_q == '0) || (n2_q == '0);
		end
		if (cmd.subt) begin
			if ({{(PROD_W-RSUM_W){1'b0}}, rsum_q} <= sub_q) ud_q <= '0;
			else if (diff > PROD_W'(2097152)) ud_q <= UD_W'(2097152);
			else ud_q <= diff[UD_W-1:0];
		end
		if (cmd.div_init) begin
			divd_q <= {1'b0, num, {FRAC_W{1'b0}}} + DIVD_W'(den_q >> 1);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			divd_q <= {divd_q[DIVD_W-2:0], 1'b0};
			rem_q  <= ge ? PROD_W'(trial - {1'b0, den_q}) : trial[PROD_W-1:0];
			quo_q  <= {quo_q[AUC_W-2:0], ge};
		end
		if (cmd.emit) begin
			out_ud  <= ud_q;
			out_err <= err_q;
			if (err_q) out_auc <= '0;
			else if (quo_q > AUC_W'(65536)) out_auc <= AUC_W'(65536);
			else out_auc <= quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q        <= '0;
			n2_q        <= '0;
			cnt_q       <= '0;
			vcnt_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			mrun_q      <= '0;
			below_q     <= '0;
			equal_q     <= '0;
			rsum_q      <= '0;
			cmp_s1      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_N1: n1_q <= cfg_data;
					REG_N2: n2_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load && (cnt_q < CNT_W'(MAX_ITEMS))) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				vcnt_q <= vcnt_q + CNT_W'(!in_miss);
			end
			if (cmd.start) begin
				i_q    <= '0;
				mrun_q <= '0;
				rsum_q <= '0;
			end
			if (cmd.add_miss) rsum_q <= rsum_q + RSUM_W'(mrank);
			if (cmd.add_valid) rsum_q <= rsum_q + RSUM_W'(vrank);
			if (cmd.scan_init) begin
				j_q     <= '0;
				below_q <= '0;
				equal_q <= '0;
			end
			if (cmd.scan_rd) j_q <= j_q + CNT_W'(1);
			cmp_s1 <= cmd.scan_rd;
			if (cmp_s1 && !rd_miss) begin
				if ($signed(rd_score) < $signed(cur_score_q)) below_q <= below_q + CNT_W'(1);
				else if (rd_score == cur_score_q) equal_q <= equal_q + CNT_W'(1);
			end
			if (cmd.next_i) begin
				i_q    <= i_q + CNT_W'(1);
				mrun_q <= mrun_q + CNT_W'(cur_miss_q);
			end
			if (cmd.div_init) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				vcnt_q      <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: test/rank_sum_auroc_chk.sv
`timescale 1ns / 1ps
module rank_sum_auroc_chk import rsa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // score
	input  wire logic [1:0]  s_axis_tuser,   // label, is_missing
	input  wire logic        s_axis_tlast,   // last
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [39:0] m_axis_tdata,   // auc[16:0], u_doubled[38:17], zero
	input  wire logic        m_axis_tuser,   // error
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [16:0] auc;
		logic [21:0] u2;
		logic        err;
	} auroc_t;

	logic signed [31:0] score_mem [MAX_ITEMS];
	logic               label_mem [MAX_ITEMS];
	logic               miss_mem  [MAX_ITEMS];
	int                 stored;
	logic [10:0]        n1_reg, n2_reg;
	auroc_t             auroc_q [$];

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		errors++;
	endtask

	// rank sum over the stored set, then U and AUC
	function automatic auroc_t predict_auroc();
		auroc_t r;
		longint unsigned rsum, sub, ud, den, num, q, vtot, below, equal, mb;
		rsum = 0;
		vtot = 0;
		for (int i = 0; i < stored; i++)
			if (!miss_mem[i]) vtot++;
		for (int i = 0; i < stored; i++) begin
			if (label_mem[i] == 1'b0) begin
				if (miss_mem[i]) begin
					mb = 0;
					for (int j = 0; j < i; j++)
						if (miss_mem[j]) mb++;
					rsum += 2 * (vtot + mb + 1);
				end else begin
					below = 0;
					equal = 0;
					for (int j = 0; j < stored; j++) begin
						if (miss_mem[j]) continue;
						if (score_mem[j] < score_mem[i]) below++;
						else if (score_mem[j] == score_mem[i]) equal++;
					end
					rsum += 2 * below + equal + 1;
				end
			end
		end
		sub = longint'(n1_reg) * (longint'(n1_reg) + 1);
		ud = (rsum > sub) ? rsum - sub : 0;
		if (ud > 2097152) ud = 2097152;
		r.u2 = ud[21:0];
		r.err = (n1_reg == 0 || n2_reg == 0);
		q = 0;
		if (!r.err) begin
			den = 2 * longint'(n1_reg) * longint'(n2_reg);
			num = (den > ud) ? den - ud : 0;
			q = (num * 65536 + den / 2) / den;
			if (q > 65536) q = 65536;
		end
		r.auc = q[16:0];
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		stored = 0;
		n1_reg = '0;
		n2_reg = '0;
	end

	always @(posedge clk) begin
		auroc_t e;
		if (arst_n) begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_N1) n1_reg = cfg_data;
				else n2_reg = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (stored < MAX_ITEMS) begin
					score_mem[stored] = s_axis_tdata;
					label_mem[stored] = s_axis_tuser[0];
					miss_mem[stored]  = s_axis_tuser[1];
					stored++;
				end
				if (s_axis_tlast) begin
					auroc_q.push_back(predict_auroc());
					stored = 0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (auroc_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					e = auroc_q.pop_front();
					if (m_axis_tdata[16:0] !== e.auc)
						report_mismatch($sformatf("auc %0d, expected %0d",
							m_axis_tdata[16:0], e.auc));
					if (m_axis_tdata[38:17] !== e.u2)
						report_mismatch($sformatf("u_doubled %0d, expected %0d",
							m_axis_tdata[38:17], e.u2));
					if (m_axis_tdata[39] !== 1'b0)
						report_mismatch("tdata padding bit not zero");
					if (m_axis_tuser !== e.err)
						report_mismatch($sformatf("error %b, expected %b",
							m_axis_tuser, e.err));
				end
			end
			pending = auroc_q.size();
		end
	end

	final begin
	end

endmodule

FILE: test/rank_sum_auroc_tb.sv
`timescale 1ns / 1ps
module rank_sum_auroc_tb;
	import rsa_pkg::*;

	localparam int WATCHDOG = 20000; // worst gap: the long receiver hold-off or a 40-item set
	localparam int SETTLE   = 80;    // idle cycles before a register write and at the end

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [10:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // score
	logic [1:0]  s_axis_tuser;   // label, is_missing
	logic        s_axis_tlast;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // auc[16:0], u_doubled[38:17], zero
	logic        m_axis_tuser;   // error

	int errors, pending;
	int send_idle, recv_stall;   // per cent
	int cycle_no, hold_until, quiet;
	int sent;

	// one data set, built before sending so its group counts are known
	logic [31:0] set_score [1100];
	logic        set_label [1100];
	logic        set_miss  [1100];
	int          set_len;

	rank_sum_auroc u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	rank_sum_auroc_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off while cycle_no < hold_until
	always @(negedge clk) begin
		if (cycle_no < hold_until) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every result is in, then let the block settle
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one word; tvalid stays high between back-to-back words
	task automatic send_word(input logic [31:0] sc, input logic lb, input logic ms,
		input logic lst);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sc;
		s_axis_tuser <= {ms, lb};
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_set(input bit matched);
		int c0, c1;
		c0 = 0;
		c1 = 0;
		for (int i = 0; i < set_len && i < MAX_ITEMS; i++)
			if (set_label[i]) c1++; else c0++;
		// idle here: nothing in flight once drained
		if (matched) begin
			drain();
			write_reg(REG_N1, 11'(c0));
			write_reg(REG_N2, 11'(c1));
		end
		for (int i = 0; i < set_len; i++)
			send_word(set_score[i], set_label[i], set_miss[i], i == set_len - 1);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// tie-prone scores mostly, with the extremes and full-range values mixed in
	function automatic logic [31:0] pick_score();
		case ($urandom_range(9)) inside
			0, 1: pick_score = $urandom;
			2: pick_score = 32'h8000_0000;
			3: pick_score = 32'h7fff_ffff;
			default: pick_score = $urandom_range(15) - 8;
		endcase
	endfunction

	task automatic random_set(input int len, input int p0, input int pmiss);
		set_len = len;
		for (int i = 0; i < len; i++) begin
			set_score[i] = pick_score();
			set_label[i] = ($urandom_range(99) >= p0);
			set_miss[i] = ($urandom_range(99) < pmiss);
		end
	endtask

	initial begin
		int ph;
		bit matched;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		cycle_no = 0;
		hold_until = 0;
		quiet = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: counts still zero after reset, so the error flag first
		set_len = 2;
		set_score[0] = 32'h0000_0001; set_label[0] = 0; set_miss[0] = 0;
		set_score[1] = 32'hffff_ffff; set_label[1] = 1; set_miss[1] = 0;
		send_set(0);
		// single-item set
		set_len = 1;
		set_score[0] = 32'h7fff_ffff; set_label[0] = 0; set_miss[0] = 0;
		send_set(1);
		// extremes, ties across groups, missing in both groups
		set_len = 10;
		set_score[0] = 32'h8000_0000; set_label[0] = 0; set_miss[0] = 0;
		set_score[1] = 32'h7fff_ffff; set_label[1] = 1; set_miss[1] = 0;
		set_score[2] = 32'h0000_0000; set_label[2] = 0; set_miss[2] = 0;
		set_score[3] = 32'h0000_0000; set_label[3] = 1; set_miss[3] = 0;
		set_score[4] = 32'hffff_ffff; set_label[4] = 0; set_miss[4] = 1;
		set_score[5] = 32'h0000_0000; set_label[5] = 0; set_miss[5] = 0;
		set_score[6] = 32'h1234_5678; set_label[6] = 1; set_miss[6] = 1;
		set_score[7] = 32'h8000_0000; set_label[7] = 1; set_miss[7] = 0;
		set_score[8] = 32'h0000_0000; set_label[8] = 0; set_miss[8] = 1;
		set_score[9] = 32'h7fff_ffff; set_label[9] = 0; set_miss[9] = 0;
		send_set(1);
		// all label 0 ranked below label 1 (AUC 1), then the reverse (AUC 0)
		set_len = 4;
		for (int i = 0; i < 4; i++) begin
			set_score[i] = i; set_label[i] = i >= 2; set_miss[i] = 0;
		end
		send_set(1);
		for (int i = 0; i < 4; i++) set_label[i] = i < 2;
		send_set(1);
		// counts disagreeing with the labels, at the top of the range
		drain();
		write_reg(REG_N1, 11'd1024);
		write_reg(REG_N2, 11'd1024);
		send_set(0);

		// random phases; idling cycles through the four modes
		ph = 0;
		while (sent < 580) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 51; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 51; end
				default: begin send_idle = 36; recv_stall = 36; end
			endcase
			matched = (ph % 3 == 0);
			if (!matched) begin
				drain();
				case (ph % 6)
					1: begin
						write_reg(REG_N1, 11'd0);
						write_reg(REG_N2, 11'($urandom_range(9)));
					end
					2: begin
						write_reg(REG_N1, 11'($urandom_range(9) + 1));
						write_reg(REG_N2, 11'd0);
					end
					4: begin write_reg(REG_N1, 11'd1); write_reg(REG_N2, 11'd1); end
					default: begin
						write_reg(REG_N1, 11'($urandom_range(1024)));
						write_reg(REG_N2, 11'($urandom_range(1024)));
					end
				endcase
			end
			for (int k = 0; k < 8; k++) begin
				random_set($urandom_range(12) + 1, $urandom_range(100), $urandom_range(30));
				send_set(matched);
			end
			if (ph == 2) begin
				// long receiver hold-off while sets keep coming: the output
				// register fills and the input stalls
				drain();
				hold_until = cycle_no + 1500;
				for (int k = 0; k < 4; k++) begin
					random_set(3, 50, 10);
					send_set(0);
				end
				// sender waits for every result
				drain();
			end
			// one medium set per phase
			random_set($urandom_range(40, 20), 40, 15);
			send_set(matched);
			ph++;
		end

		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rsa_pkg.sv
rtl/core/rsa_ctrl.sv
rtl/core/rsa_dp.sv
rtl/core/rank_sum_auroc.sv
test/rank_sum_auroc_chk.sv
test/rank_sum_auroc_tb.sv
